// ----- hdl/lfuc_pkg.sv -----
// Shared types and constants for the LFU cache with LRU tie-break.
package lfuc_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CAP_W   = 5;

    // Build-time defaults
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int RAM_WIDTH_DEF   = 84;

    // Register reset and special values
    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 16'd1;
    localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
    localparam logic [DATA_W-1:0]  PUT_VALUE  = '0;

    // Request codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_DONE
    } state_t;

endpackage

// ----- hdl/lfuc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lfuc_ram
    import lfuc_pkg::*;
#(
    parameter int WIDTH = RAM_WIDTH_DEF,
    parameter int DEPTH = MAX_ENTRIES_DEF
)
(
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/lfu_cache_with_lru_tiebreak.sv -----
// LFU key-value cache with least-recently-used tie-break: top level.
//
// Channels: a request channel (in_valid/in_ready with action, key, value), a
// result channel (out_valid/out_ready with hit, read_value) and a capacity
// write channel (cfg_valid/cfg_ready with cfg_data), all valid/ready.
// Every request gives exactly one result: get hit returns the stored value,
// get miss returns -1 with hit low, put returns 0 with hit telling whether
// the key was already present.
// Each entry (key, data, use count, recency rank) sits in one RAM word; valid
// bits and the fill count sit in flip-flops. A request makes one read pass
// over all MAX_ENTRIES words to find the key, the first free slot and the
// victim (lowest count, then oldest rank), decides in S_DECIDE, then
// makes a second read-modify-write pass to adjust ranks and write the target.
// A hit or an inserting put makes both passes; a get miss or a put that
// stores nothing makes only the first. The next request is taken in the
// cycle after the result is loaded; the two passes over the single RAM
// read port set the rate.
// Reset empties the cache at once (valid bits clear) and sets capacity to 16.
// A stalled result waits in the output register while the next request is
// accepted; that request then holds in its last cycle until the register
// frees.
module lfu_cache_with_lru_tiebreak
    import lfuc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [DATA_W-1:0] value,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,
    // capacity write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW = IW;
    localparam int HW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (HW > CAP_W) ? HW : CAP_W;
    localparam int EW = KEY_W + DATA_W + COUNT_W + RW;
    localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] CAP_LIMIT = CW'(MAX_ENTRIES);

    // Control state
    state_t state_reg, state_next;
    logic [CAP_W-1:0]       capacity_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [HW-1:0]          held_reg;
    logic                   out_valid_reg;
    logic                   issue_reg;
    logic [IW-1:0]          idx_reg;
    logic                   rsp_vld_reg;
    logic [IW-1:0]          rsp_idx_reg;

    // Request capture
    logic                   action_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [DATA_W-1:0]      value_reg;

    // Scan results
    logic                   fnd_reg;
    logic [IW-1:0]          fidx_reg;
    logic [RW-1:0]          frank_reg;
    logic [DATA_W-1:0]      fdata_reg;
    logic                   free_fnd_reg;
    logic [IW-1:0]          free_idx_reg;
    logic                   vic_fnd_reg;
    logic [IW-1:0]          vic_idx_reg;
    logic [RW-1:0]          vic_rank_reg;
    logic [COUNT_W-1:0]     vic_count_reg;

    // Decision
    logic                   ins_reg;
    logic                   evict_reg;
    logic [IW-1:0]          tgt_reg;
    logic                   res_hit_reg;
    logic [DATA_W-1:0]      res_value_reg;
    logic                   hit_reg;
    logic [DATA_W-1:0]      read_value_reg;

    // Sequencer decode
    logic in_xfer;
    logic rd_en;
    logic phase_start;
    logic phase_end;
    logic out_load;

    // RAM ports
    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;

    // Entry fields of the word just read
    logic [KEY_W-1:0]   ent_key;
    logic [DATA_W-1:0]  ent_data;
    logic [COUNT_W-1:0] ent_count;
    logic [RW-1:0]      ent_rank;
    logic               ent_valid;

    // Decision terms
    logic               is_put;
    logic [CW-1:0]      cap_ext;
    logic [CW-1:0]      cap_eff;
    logic [CW-1:0]      held_ext;
    logic [CW-1:0]      held_after;
    logic               do_evict;
    logic               do_insert;
    logic               do_update;
    logic [IW-1:0]      slot;

    // Target word fields
    logic [DATA_W-1:0]  new_data;
    logic [COUNT_W-1:0] new_count;
    logic [RW-1:0]      adj_rank;

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    assign ent_key   = rd_data[EW-1 -: KEY_W];
    assign ent_data  = rd_data[EW-KEY_W-1 -: DATA_W];
    assign ent_count = rd_data[RW +: COUNT_W];
    assign ent_rank  = rd_data[RW-1:0];
    assign ent_valid = valid_reg[rsp_idx_reg];

    // Entry store
    lfuc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rsp_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (phase_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = do_update ? S_UPDATE : S_DONE;
            end
            S_UPDATE:
            begin
                if (phase_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        phase_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                phase_start = in_valid;
            end
            S_SCAN:
            begin
                rd_en = issue_reg;
            end
            S_DECIDE:
            begin
                phase_start = do_update;
            end
            S_UPDATE:
            begin
                rd_en = issue_reg;
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_xfer   = in_valid && in_ready;
    assign phase_end = rsp_vld_reg && (rsp_idx_reg == LAST_IDX);

    // Work out eviction and insertion from the scan results
    always_comb
    begin
        is_put     = (action_reg == ACT_PUT);
        cap_ext    = CW'(capacity_reg);
        cap_eff    = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
        held_ext   = CW'(held_reg);
        do_evict   = is_put && !fnd_reg && (held_ext == cap_eff) && (held_ext != '0);
        held_after = held_ext - CW'(do_evict);
        do_insert  = is_put && !fnd_reg && (held_after < cap_eff);
        do_update  = fnd_reg || do_insert;
        if (do_evict)
        begin
            slot = (free_fnd_reg && (free_idx_reg < vic_idx_reg)) ? free_idx_reg : vic_idx_reg;
        end
        else
        begin
            slot = free_idx_reg;
        end
    end

    // Drop the victim, claim the slot
    always_comb
    begin
        valid_next = valid_reg;
        if (state_reg == S_DECIDE)
        begin
            if (do_evict)
            begin
                valid_next[vic_idx_reg] = 1'b0;
            end
            if (do_insert)
            begin
                valid_next[slot] = 1'b1;
            end
        end
    end

    // Build the write-back word for the entry just read
    always_comb
    begin
        new_data  = is_put ? value_reg : ent_data;
        new_count = ins_reg ? COUNT_ONE :
                    ((ent_count == COUNT_MAX) ? ent_count : ent_count + COUNT_ONE);
        if (ins_reg)
        begin
            adj_rank = ent_rank + RW'(1) - RW'(evict_reg && (ent_rank > vic_rank_reg));
        end
        else
        begin
            adj_rank = ent_rank + RW'(ent_rank < frank_reg);
        end
        wr_en   = 1'b0;
        wr_data = rd_data;
        if (state_reg == S_UPDATE && rsp_vld_reg)
        begin
            if (rsp_idx_reg == tgt_reg)
            begin
                wr_en   = 1'b1;
                wr_data = {key_reg, new_data, new_count, RW'(0)};
            end
            else if (ent_valid)
            begin
                wr_en   = 1'b1;
                wr_data = {ent_key, ent_data, ent_count, adj_rank};
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_RESET;
            valid_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            issue_reg     <= 1'b0;
            idx_reg       <= '0;
            rsp_vld_reg   <= 1'b0;
            rsp_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;

            // Capacity transfer
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end

            // Address sweep for either pass
            if (phase_start)
            begin
                idx_reg   <= '0;
                issue_reg <= 1'b1;
            end
            else if (rd_en)
            begin
                if (idx_reg == LAST_IDX)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            rsp_vld_reg <= rd_en;
            rsp_idx_reg <= idx_reg;

            // Advance the fill count
            if (state_reg == S_DECIDE)
            begin
                held_reg <= held_reg - HW'(do_evict) + HW'(do_insert);
            end

            // Output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Capture the request and clear the scan trackers
        if (in_xfer)
        begin
            action_reg   <= action;
            key_reg      <= key;
            value_reg    <= value;
            fnd_reg      <= 1'b0;
            free_fnd_reg <= 1'b0;
            vic_fnd_reg  <= 1'b0;
        end

        // Track first match, first free slot and victim during the scan
        if (state_reg == S_SCAN && rsp_vld_reg)
        begin
            if (ent_valid)
            begin
                if (!fnd_reg && ent_key == key_reg)
                begin
                    fnd_reg   <= 1'b1;
                    fidx_reg  <= rsp_idx_reg;
                    frank_reg <= ent_rank;
                    fdata_reg <= ent_data;
                end
                if (!vic_fnd_reg || ent_count < vic_count_reg ||
                    (ent_count == vic_count_reg && ent_rank > vic_rank_reg))
                begin
                    vic_fnd_reg   <= 1'b1;
                    vic_idx_reg   <= rsp_idx_reg;
                    vic_rank_reg  <= ent_rank;
                    vic_count_reg <= ent_count;
                end
            end
            else if (!free_fnd_reg)
            begin
                free_fnd_reg <= 1'b1;
                free_idx_reg <= rsp_idx_reg;
            end
        end

        // Settle the update and the result
        if (state_reg == S_DECIDE)
        begin
            ins_reg     <= do_insert;
            evict_reg   <= do_evict;
            tgt_reg     <= fnd_reg ? fidx_reg : slot;
            res_hit_reg <= fnd_reg;
            if (is_put)
            begin
                res_value_reg <= PUT_VALUE;
            end
            else
            begin
                res_value_reg <= fnd_reg ? fdata_reg : MISS_VALUE;
            end
        end

        if (out_load)
        begin
            hit_reg        <= res_hit_reg;
            read_value_reg <= res_value_reg;
        end
    end

endmodule

// ----- hdl/lfuc_checker.sv -----
// Port-level checker for the LFU cache, bound to the top level.
module lfuc_checker
    import lfuc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     hit,
    input logic signed [DATA_W-1:0] read_value,
    input logic                     cfg_valid,
    input logic                     cfg_ready
);

    // One request at a time: busy after a request transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a previous request is in work");

    // A fresh result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a request in work");

    // A miss reads as -1 for a get or 0 for a put
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (read_value == MISS_VALUE) || (read_value == PUT_VALUE))
        else $error("miss result carries a stored value");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
        else $error("stalled result changed");

    // Capacity writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("capacity write stalled");

endmodule

bind lfu_cache_with_lru_tiebreak lfuc_checker u_lfuc_checker (.*);

// ----- dv/lfu_cache_with_lru_tiebreak_test.sv -----
// Self-checking testbench for the LFU cache with LRU tie-break.
module lfu_cache_with_lru_tiebreak_test;
    import lfuc_pkg::*;

    localparam int ENTRIES     = MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 10;

    // Tracks cache contents, predicts each result and checks it in order
    class cache_scoreboard;
        typedef struct packed {
            logic              hit;
            logic [DATA_W-1:0] read_value;
        } outcome_t;

        logic [CAP_W-1:0]   capacity;
        bit                 slot_used [ENTRIES];
        logic [KEY_W-1:0]   slot_key  [ENTRIES];
        logic [DATA_W-1:0]  slot_data [ENTRIES];
        logic [COUNT_W-1:0] slot_count[ENTRIES];
        int                 slot_rank [ENTRIES];
        outcome_t           awaited_outcomes[$];
        int                 mismatches;
        int                 requests;
        int                 hits;
        int                 evictions;
        int                 cap_writes;

        function new();
            capacity = CAP_RESET;
            foreach (slot_used[i]) slot_used[i] = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
            cap_writes++;
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction

        // Bump the use count (saturating) and make entry e the most recent
        function void touch(int e);
            if (slot_count[e] != COUNT_MAX)
                slot_count[e]++;
            foreach (slot_used[i])
                if (slot_used[i] && i != e && slot_rank[i] < slot_rank[e])
                    slot_rank[i]++;
            slot_rank[e] = 0;
        endfunction

        // Work out the result of one accepted request and update the contents
        function void predict_request(logic act, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
            int       found;
            int       held;
            int       eff_cap;
            int       victim;
            int       free_slot;
            outcome_t res;
            found     = -1;
            held      = 0;
            victim    = -1;
            free_slot = -1;
            eff_cap   = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
            requests++;
            foreach (slot_used[i])
                if (slot_used[i]) begin
                    held++;
                    if (found < 0 && slot_key[i] == k)
                        found = i;
                end
            if (act == ACT_GET) begin
                if (found >= 0) begin
                    touch(found);
                    res.hit        = 1'b1;
                    res.read_value = slot_data[found];
                end
                else begin
                    res.hit        = 1'b0;
                    res.read_value = MISS_VALUE;
                end
            end
            else begin
                res.read_value = PUT_VALUE;
                res.hit        = (found >= 0);
                if (found >= 0) begin
                    slot_data[found] = v;
                    touch(found);
                end
                else begin
                    // Evict the lowest count, oldest first, when exactly full
                    if (held == eff_cap && held > 0) begin
                        foreach (slot_used[i])
                            if (slot_used[i] && (victim < 0 ||
                                slot_count[i] < slot_count[victim] ||
                                (slot_count[i] == slot_count[victim] &&
                                 slot_rank[i] > slot_rank[victim])))
                                victim = i;
                        slot_used[victim] = 0;
                        foreach (slot_used[i])
                            if (slot_used[i] && slot_rank[i] > slot_rank[victim])
                                slot_rank[i]--;
                        held--;
                        evictions++;
                    end
                    // Insert into the first free slot as the most recent entry
                    if (held < eff_cap) begin
                        foreach (slot_used[i])
                            if (!slot_used[i] && free_slot < 0)
                                free_slot = i;
                        if (free_slot >= 0) begin
                            foreach (slot_used[i])
                                if (slot_used[i])
                                    slot_rank[i]++;
                            slot_used[free_slot]  = 1;
                            slot_key[free_slot]   = k;
                            slot_data[free_slot]  = v;
                            slot_count[free_slot] = COUNT_ONE;
                            slot_rank[free_slot]  = 0;
                        end
                    end
                end
            end
            if (res.hit)
                hits++;
            awaited_outcomes.push_back(res);
        endfunction

        function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0d, got %0d", what, $signed(want), $signed(got));
        endfunction

        // Compare one transferred result with the oldest prediction
        function void check_result(logic h, logic [DATA_W-1:0] rv);
            outcome_t want;
            if (awaited_outcomes.size() == 0) begin
                report("unexpected result, read_value", '0, rv);
                return;
            end
            want = awaited_outcomes.pop_front();
            if (h !== want.hit)
                report("hit", DATA_W'(want.hit), DATA_W'(h));
            if (rv !== want.read_value)
                report("read_value", want.read_value, rv);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     action;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;

    cache_scoreboard sb = new();
    logic [KEY_W-1:0] key_pool[24];
    bit               quiet;
    int               stall_left;
    int               cycles;

    lfu_cache_with_lru_tiebreak dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .read_value(read_value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(logic a, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        key      <= k;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        sb.predict_request(a, k, v);
    endtask

    // Drain all results, then write the capacity register
    task automatic write_capacity(logic [CAP_W-1:0] c);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge clk); while (!cfg_ready);
        sb.set_capacity(c);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random request, keys mostly from a pool sized to the capacity
    task automatic random_request(int eff_cap);
        int               span;
        logic [KEY_W-1:0] k;
        logic [DATA_W-1:0] v;
        span = (2 * eff_cap + 3 > 23) ? 23 : 2 * eff_cap + 3;
        k = ($urandom_range(0, 9) < 9) ? key_pool[$urandom_range(0, span)] : $urandom;
        v = ($urandom_range(0, 15) == 0) ? key_pool[$urandom_range(0, 3)] : $urandom;
        send_request($urandom_range(0, 99) < 45 ? ACT_PUT : ACT_GET, k, v);
    endtask

    // Stall the result side at random
    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    stall_left = pick_gap();
            end
        end
    end

    // Check every result transfer
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(hit, read_value);

    // Guard against a hang
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int caps[11];
        int eff;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_GET;
        key       = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet     = 1'b0;
        cycles    = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Empty cache, extreme keys and values, put over a present key
        send_request(ACT_GET, 32'h0, 32'h0);
        send_request(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_request(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(ACT_GET, 32'h8000_0000, 32'h0);
        send_request(ACT_PUT, 32'h7fff_ffff, 32'h0);
        send_request(ACT_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(ACT_GET, 32'h0, 32'h0);

        // Capacity lowered below the held count: absent puts store nothing
        write_capacity(5'd2);
        send_request(ACT_PUT, 32'd5, 32'd55);
        send_request(ACT_GET, 32'd5, 32'd0);
        send_request(ACT_GET, 32'hffff_ffff, 32'd0);

        // Capacity above the built size behaves as full size
        write_capacity(5'd31);
        send_request(ACT_PUT, 32'd5, 32'd55);
        send_request(ACT_GET, 32'd5, 32'd0);

        // Full cache: lowest count goes, oldest among equal counts
        write_capacity(5'd4);
        send_request(ACT_PUT, 32'd7, 32'd77);
        send_request(ACT_GET, 32'd5, 32'd0);
        send_request(ACT_GET, 32'd7, 32'd0);
        send_request(ACT_PUT, 32'd8, 32'd88);
        send_request(ACT_GET, 32'h8000_0000, 32'd0);

        // Capacity zero: nothing new is stored
        write_capacity(5'd0);
        send_request(ACT_PUT, 32'd9, 32'd99);
        send_request(ACT_GET, 32'd9, 32'd0);
        send_request(ACT_GET, 32'hffff_ffff, 32'd0);

        // Random phases over a spread of capacities
        caps = '{16, 1, 2, 0, 31, 5, 3, 8, 17, 0, 0};
        caps[9]  = $urandom_range(0, 31);
        caps[10] = $urandom_range(0, 31);
        foreach (caps[p]) begin
            write_capacity(caps[p][CAP_W-1:0]);
            quiet = ($urandom_range(0, 3) == 0);
            eff   = (caps[p] > ENTRIES) ? ENTRIES : caps[p];
            repeat (48) random_request(eff);
        end
        quiet = 1'b0;

        // Let the last results arrive
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Covered %0d requests (%0d hits, %0d evictions) over %0d capacity writes.",
                 sb.requests, sb.hits, sb.evictions, sb.cap_writes);
        $display("%0d field mismatches, %0d results outstanding.", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lfuc_pkg.sv
hdl/lfuc_ram.sv
hdl/lfu_cache_with_lru_tiebreak.sv
hdl/lfuc_checker.sv
dv/lfu_cache_with_lru_tiebreak_test.sv
